// ===== rtl/vnorm_pkg.sv =====
// Package for the 3D vector normalization unit.
// Holds the item structs and fixed format constants; depends on nothing.
package vnorm_pkg;

    localparam int FIELD_W = 32;   // width of every component field
    localparam int Q_FRAC  = 30;   // fraction bits of the Q1.30 result
    localparam int QUOT_W  = Q_FRAC + 1;
    localparam int MINL_W  = 16;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x_in;
        logic signed [FIELD_W-1:0] y_in;
        logic signed [FIELD_W-1:0] z_in;
    } in_item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x_out;
        logic signed [FIELD_W-1:0] y_out;
        logic signed [FIELD_W-1:0] z_out;
        logic                      too_short;
    } out_item_t;

endpackage

// ===== rtl/vnorm_sqrt_cell.sv =====
// One cell of the square root chain: resolves one root bit per item.
// Uses no package items; instantiated by vec3_normalize_unit.
module vnorm_sqrt_cell #(
    parameter int W = 32,
    parameter int SIDE_W = 99
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  logic [2*W-1:0]    rad_in,
    input  logic [W:0]        rem_in,
    input  logic [W-1:0]      root_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output logic [2*W-1:0]    rad_out,
    output logic [W:0]        rem_out,
    output logic [W-1:0]      root_out,
    output logic [SIDE_W-1:0] side_out
);

    logic              valid_reg;
    logic [2*W-1:0]    rad_reg;
    logic [W:0]        rem_reg;
    logic [W-1:0]      root_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [W+2:0]      wide_rem;
    logic [W+2:0]      trial;
    logic [W:0]        rem_next;
    logic [W-1:0]      root_next;

    always_comb
    begin
        wide_rem = {rem_in, rad_in[2*W-1 -: 2]};
        trial    = {1'b0, root_in, 2'b01};
        if (wide_rem >= trial)
        begin
            rem_next  = (W+1)'(wide_rem - trial);
            root_next = {root_in[W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = wide_rem[W:0];
            root_next = {root_in[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= {rad_in[2*W-3:0], 2'b00};
        rem_reg  <= rem_next;
        root_reg <= root_next;
        side_reg <= side_in;
    end

    assign valid_out = valid_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign side_out  = side_reg;

endmodule

// ===== rtl/vnorm_div_cell.sv =====
// One cell of the division chain: one quotient bit for each of three lanes.
// Uses vnorm_pkg for the quotient width; instantiated by vec3_normalize_unit.
module vnorm_div_cell #(
    parameter int W = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    input  logic                          short_in,
    input  logic [W-1:0]                  len_in,
    input  logic [2:0]                    neg_in,
    input  logic [2:0]                    bit_in,
    input  logic [3*W-1:0]                rem_in,
    input  logic [3*vnorm_pkg::QUOT_W-1:0] quot_in,
    output logic                          valid_out,
    output logic                          short_out,
    output logic [W-1:0]                  len_out,
    output logic [2:0]                    neg_out,
    output logic [3*W-1:0]                rem_out,
    output logic [3*vnorm_pkg::QUOT_W-1:0] quot_out
);

    localparam int QW = vnorm_pkg::QUOT_W;

    logic                valid_reg;
    logic                short_reg;
    logic [W-1:0]        len_reg;
    logic [2:0]          neg_reg;
    logic [3*W-1:0]      rem_reg;
    logic [3*QW-1:0]     quot_reg;
    logic [3*W-1:0]      rem_next;
    logic [3*QW-1:0]     quot_next;
    logic [W:0]          part [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            part[i] = {rem_in[i*W +: W], bit_in[i]};
            if (part[i] >= {1'b0, len_in})
            begin
                rem_next[i*W +: W]   = W'(part[i] - {1'b0, len_in});
                quot_next[i*QW +: QW] = {quot_in[i*QW +: QW-1], 1'b1};
            end
            else
            begin
                rem_next[i*W +: W]   = part[i][W-1:0];
                quot_next[i*QW +: QW] = {quot_in[i*QW +: QW-1], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        short_reg <= short_in;
        len_reg   <= len_in;
        neg_reg   <= neg_in;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
    end

    assign valid_out = valid_reg;
    assign short_out = short_reg;
    assign len_out   = len_reg;
    assign neg_out   = neg_reg;
    assign rem_out   = rem_reg;
    assign quot_out  = quot_reg;

endmodule

// ===== rtl/vec3_normalize_unit.sv =====
// Top level of the 3D vector normalization unit.
// Depends on vnorm_pkg, vnorm_sqrt_cell and vnorm_div_cell.
//
// Usage: drive a vector on in_item and raise start. busy is always low, so an
// item is taken at every clock edge where start is high, one vector per clock.
// Each item yields exactly one result item on out_item, shown for a single
// cycle with done high. The receiver cannot hold results off and need not.
// From the accepting edge to the edge that raises done, an item passes these
// registers in order: sign removal (registered at the accepting edge), the
// squaring and summing stages, COMP_WIDTH cells of the square root chain (one
// root bit per cell), 31 cells of the division chain (one quotient bit per
// cell, three lanes each) and the output register.
// The length is the floor square root of the sum of squares; when it is not
// above min_length the result is the zero vector with too_short set.
// min_length is written through cfg_valid/cfg_data; cfg_ready is always high.
// Reset clears min_length and all valid bits in the chains, so no stray done
// pulse appears after reset; payload registers are not reset.
module vec3_normalize_unit #(
    parameter int COMP_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  vnorm_pkg::in_item_t              in_item,
    output logic                             done,
    output vnorm_pkg::out_item_t             out_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vnorm_pkg::MINL_W-1:0]     cfg_data
);

    localparam int W      = COMP_WIDTH;
    localparam int QW     = vnorm_pkg::QUOT_W;
    localparam int FW     = vnorm_pkg::FIELD_W;
    localparam int SIDE_W = 3 * W + 3;

    // Configuration register.
    logic [vnorm_pkg::MINL_W-1:0] min_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_len_reg <= '0;
        else if (cfg_valid)
            min_len_reg <= cfg_data;
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // Stage 1: magnitude and sign of each component's low COMP_WIDTH bits.
    logic         s1_valid_reg;
    logic [W-1:0] s1_mag_reg [0:2];
    logic [2:0]   s1_neg_reg;
    logic [W-1:0] raw [0:2];

    assign raw[0] = in_item.x_in[W-1:0];
    assign raw[1] = in_item.y_in[W-1:0];
    assign raw[2] = in_item.z_in[W-1:0];

    // Stage 2: squares. Stage 3: sum, which fits 2*W bits.
    logic           s2_valid_reg;
    logic [2*W-1:0] s2_sq_reg [0:2];
    logic [W-1:0]   s2_mag_reg [0:2];
    logic [2:0]     s2_neg_reg;
    logic           s3_valid_reg;
    logic [2*W-1:0] s3_sum_reg;
    logic [SIDE_W-1:0] s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_neg_reg[i] <= raw[i][W-1];
            s1_mag_reg[i] <= raw[i][W-1] ? (W'(0) - raw[i]) : raw[i];
            s2_sq_reg[i]  <= {{W{1'b0}}, s1_mag_reg[i]} * {{W{1'b0}}, s1_mag_reg[i]};
            s2_mag_reg[i] <= s1_mag_reg[i];
        end
        s2_neg_reg  <= s1_neg_reg;
        s3_sum_reg  <= s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];
        s3_side_reg <= {s2_neg_reg, s2_mag_reg[2], s2_mag_reg[1], s2_mag_reg[0]};
    end

    // Square root chain: W cells, each settling one root bit.
    logic              sq_valid [0:W];
    logic [2*W-1:0]    sq_rad   [0:W];
    logic [W:0]        sq_rem   [0:W];
    logic [W-1:0]      sq_root  [0:W];
    logic [SIDE_W-1:0] sq_side  [0:W];

    assign sq_valid[0] = s3_valid_reg;
    assign sq_rad[0]   = s3_sum_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = s3_side_reg;

    for (genvar k = 0; k < W; k++)
    begin : g_sqrt
        vnorm_sqrt_cell #(.W(W), .SIDE_W(SIDE_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (sq_valid[k]),
            .rad_in    (sq_rad[k]),
            .rem_in    (sq_rem[k]),
            .root_in   (sq_root[k]),
            .side_in   (sq_side[k]),
            .valid_out (sq_valid[k+1]),
            .rad_out   (sq_rad[k+1]),
            .rem_out   (sq_rem[k+1]),
            .root_out  (sq_root[k+1]),
            .side_out  (sq_side[k+1])
        );
    end

    // Division chain entry. The quotient mag*2^30/len never exceeds 2^30, so
    // the dividend bits above bit 30 yield zero quotient bits and leave a
    // partial remainder of mag/2; the chain starts from there and feeds the
    // low magnitude bit, then zeros.
    logic [W-1:0]    len;
    logic [W-1:0]    mag [0:2];
    logic [2:0]      dv_bit0;
    logic            dv_valid [0:QW];
    logic            dv_short [0:QW];
    logic [W-1:0]    dv_len   [0:QW];
    logic [2:0]      dv_neg   [0:QW];
    logic [3*W-1:0]  dv_rem   [0:QW];
    logic [3*QW-1:0] dv_quot  [0:QW];

    assign len    = sq_root[W];
    assign mag[0] = sq_side[W][W-1:0];
    assign mag[1] = sq_side[W][2*W-1:W];
    assign mag[2] = sq_side[W][3*W-1:2*W];

    assign dv_valid[0] = sq_valid[W];
    assign dv_short[0] = (len <= W'(min_len_reg));
    assign dv_len[0]   = len;
    assign dv_neg[0]   = sq_side[W][3*W +: 3];
    assign dv_rem[0]   = {mag[2] >> 1, mag[1] >> 1, mag[0] >> 1};
    assign dv_quot[0]  = '0;
    assign dv_bit0     = {mag[2][0], mag[1][0], mag[0][0]};

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        vnorm_div_cell #(.W(W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (dv_valid[k]),
            .short_in  (dv_short[k]),
            .len_in    (dv_len[k]),
            .neg_in    (dv_neg[k]),
            .bit_in    ((k == 0) ? dv_bit0 : 3'b000),
            .rem_in    (dv_rem[k]),
            .quot_in   (dv_quot[k]),
            .valid_out (dv_valid[k+1]),
            .short_out (dv_short[k+1]),
            .len_out   (dv_len[k+1]),
            .neg_out   (dv_neg[k+1]),
            .rem_out   (dv_rem[k+1]),
            .quot_out  (dv_quot[k+1])
        );
    end

    // Output register: apply sign, or force the zero vector for short lengths.
    logic                 done_reg;
    vnorm_pkg::out_item_t out_reg;
    vnorm_pkg::out_item_t out_next;
    logic [FW-1:0]        lane [0:2];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lane[i] = FW'(dv_quot[QW][i*QW +: QW]);
            if (dv_neg[QW][i])
                lane[i] = FW'(0) - lane[i];
            if (dv_short[QW])
                lane[i] = '0;
        end
        out_next.x_out     = lane[0];
        out_next.y_out     = lane[1];
        out_next.z_out     = lane[2];
        out_next.too_short = dv_short[QW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid[QW];
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done     = done_reg;
    assign out_item = out_reg;

endmodule
